@@ hw/rtl/pif_pkg.sv @@
`timescale 1ns / 1ps
package pif_pkg;

  localparam int MAX_WIDTH     = 63;
  localparam int MAX_PRECISION = 60;
  localparam int NDIG          = 22;
  localparam int DIG_W         = 4 * NDIG;

  localparam logic [2:0] CONV_D   = 3'd0;
  localparam logic [2:0] CONV_U   = 3'd1;
  localparam logic [2:0] CONV_X   = 3'd2;
  localparam logic [2:0] CONV_XU  = 3'd3;
  localparam logic [2:0] CONV_O   = 3'd4;
  localparam logic [2:0] CONV_P   = 3'd5;
  localparam logic [2:0] CONV_C   = 3'd6;
  localparam logic [2:0] CONV_PCT = 3'd7;

  localparam logic [1:0] LEN_INT  = 2'd0;
  localparam logic [1:0] LEN_H    = 2'd1;
  localparam logic [1:0] LEN_L    = 2'd2;
  localparam logic [1:0] LEN_LX   = 2'd3;

  typedef struct packed {
    logic [2:0]  conversion;
    logic [63:0] value;
    logic [1:0]  length_mod;
    logic        left_justify;
    logic        force_sign;
    logic        space_sign;
    logic        alt_form;
    logic        zero_pad;
    logic [5:0]  field_width;
    logic        has_precision;
    logic [5:0]  min_digits;
  } pif_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_char;
  } pif_out_t;

  typedef struct packed {
    logic [DIG_W-1:0] dig;
    logic [4:0]       nd;
    logic [2:0]       conversion;
    logic             left;
    logic             zfill;
    logic             hp;
    logic [5:0]       prec;
    logic [5:0]       w;
    logic [1:0]       npre;
    logic [7:0]       pre0;
    logic [7:0]       pre1;
    logic             mag_zero;
    logic             alt;
    logic [7:0]       chr;
  } pif_job_t;

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] c;
    if (nib < 4'd10) c = 8'h30 + {4'd0, nib};
    else if (upper) c = 8'h37 + {4'd0, nib};
    else c = 8'h57 + {4'd0, nib};
    return c;
  endfunction

endpackage

@@ hw/rtl/pif_conv.sv @@
`timescale 1ns / 1ps
module pif_conv (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pif_pkg::pif_in_t in_data,
  output logic             job_valid,
  input  logic             job_ready,
  output pif_pkg::pif_job_t job
);
  import pif_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DAB   = 2'd1;
  localparam logic [1:0] S_STRIP = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [63:0]      mag_r, mag_nxt;
  pif_job_t         job_r, job_nxt;

  logic [63:0]      mask, vm, mag;
  logic             neg;
  logic [65:0]      oct_src;
  logic [DIG_W-1:0] oct_dig, dab_dig;
  logic [3:0]       nib;
  logic             take;

  assign in_ready  = (state_r == S_IDLE);
  assign job_valid = (state_r == S_DONE);
  assign job       = job_r;
  assign take      = in_valid && in_ready;

  always_comb begin
    mask = 64'hFFFF_FFFF_FFFF_FFFF;
    neg  = 1'b0;
    if (in_data.conversion != CONV_P) begin
      unique case (in_data.length_mod)
        LEN_INT: mask = 64'h0000_0000_FFFF_FFFF;
        LEN_H:   mask = 64'h0000_0000_0000_FFFF;
        default: mask = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
    end
    vm = in_data.value & mask;
    if (in_data.conversion == CONV_D) begin
      unique case (in_data.length_mod)
        LEN_INT: neg = vm[31];
        LEN_H:   neg = vm[15];
        default: neg = vm[63];
      endcase
    end
    mag = neg ? ((~vm + 64'd1) & mask) : vm;
    oct_src = {2'b00, mag};
    for (int k = 0; k < NDIG; k++) begin
      oct_dig[4*k +: 4] = {1'b0, oct_src[3*k +: 3]};
    end
    for (int k = 0; k < NDIG; k++) begin
      nib = job_r.dig[4*k +: 4];
      dab_dig[4*k +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mag_nxt   = mag_r;
    job_nxt   = job_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          job_nxt.conversion = in_data.conversion;
          job_nxt.left       = in_data.left_justify;
          job_nxt.hp         = in_data.has_precision;
          job_nxt.prec       = (in_data.min_digits > 6'(MAX_PRECISION)) ?
                               6'(MAX_PRECISION) : in_data.min_digits;
          job_nxt.w          = (in_data.field_width > 6'(MAX_WIDTH)) ?
                               6'(MAX_WIDTH) : in_data.field_width;
          job_nxt.alt        = in_data.alt_form;
          job_nxt.chr        = in_data.value[7:0];
          job_nxt.mag_zero   = (mag == 64'd0);
          job_nxt.zfill      = in_data.zero_pad && !in_data.left_justify &&
                               !in_data.has_precision && (in_data.conversion < CONV_C);
          job_nxt.npre       = 2'd0;
          job_nxt.pre0       = 8'h30;
          job_nxt.pre1       = (in_data.conversion == CONV_XU) ? 8'h58 : 8'h78;
          job_nxt.nd         = 5'(NDIG);
          if (in_data.conversion == CONV_D) begin
            if (neg) begin
              job_nxt.npre = 2'd1;
              job_nxt.pre0 = 8'h2D;
            end else if (in_data.force_sign) begin
              job_nxt.npre = 2'd1;
              job_nxt.pre0 = 8'h2B;
            end else if (in_data.space_sign) begin
              job_nxt.npre = 2'd1;
              job_nxt.pre0 = 8'h20;
            end
          end
          if (mag != 64'd0 && (in_data.conversion == CONV_P ||
              (in_data.alt_form && (in_data.conversion == CONV_X ||
                                    in_data.conversion == CONV_XU)))) begin
            job_nxt.npre = 2'd2;
          end
          case (in_data.conversion)
            CONV_D, CONV_U: begin
              job_nxt.dig = '0;
              mag_nxt     = mag;
              cnt_nxt     = 6'd63;
              state_nxt   = S_DAB;
            end
            CONV_O: begin
              job_nxt.dig = oct_dig;
              state_nxt   = S_STRIP;
            end
            CONV_X, CONV_XU, CONV_P: begin
              job_nxt.dig = {{(DIG_W-64){1'b0}}, mag};
              state_nxt   = S_STRIP;
            end
            default: begin
              job_nxt.dig = '0;
              state_nxt   = S_DONE;
            end
          endcase
        end
      end
      S_DAB: begin
        // shift-add-3, one value bit per cycle
        job_nxt.dig = {dab_dig[DIG_W-2:0], mag_r[63]};
        mag_nxt     = {mag_r[62:0], 1'b0};
        cnt_nxt     = cnt_r - 6'd1;
        if (cnt_r == 6'd0) state_nxt = S_STRIP;
      end
      S_STRIP: begin
        if (job_r.nd > 5'd1 && job_r.dig[DIG_W-1 -: 4] == 4'd0) begin
          job_nxt.dig = {job_r.dig[DIG_W-5:0], 4'd0};
          job_nxt.nd  = job_r.nd - 5'd1;
        end else begin
          if (job_r.mag_zero && job_r.hp && job_r.prec == 6'd0) job_nxt.nd = 5'd0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (job_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt;
    mag_r <= mag_nxt;
    job_r <= job_nxt;
  end

endmodule

@@ hw/rtl/pif_emit.sv @@
`timescale 1ns / 1ps
module pif_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  pif_pkg::pif_job_t job,
  output logic              out_valid,
  input  logic              out_ready,
  output pif_pkg::pif_out_t out_data
);
  import pif_pkg::*;

  logic              run_r;
  logic              out_valid_r;
  pif_out_t          out_r;
  logic [6:0]        pos_r, a_r, b_r, c_r, d_r, total_r;
  logic [DIG_W-1:0]  dig_r;
  logic [2:0]        conv_r;
  logic [7:0]        pre0_r, pre1_r, chr_r;

  logic [6:0] nd7, zr, body, pad, a, b, c, d, total;
  logic       is_int, fire, in_dig;
  logic [7:0] ch;

  assign job_ready = !run_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign fire      = run_r && (!out_valid_r || out_ready);

  always_comb begin
    is_int = (job.conversion < CONV_C);
    nd7    = is_int ? {2'b00, job.nd} : 7'd1;
    zr     = 7'd0;
    if (is_int && job.hp && {1'b0, job.prec} > nd7) zr = {1'b0, job.prec} - nd7;
    // octal alternate form needs a leading zero digit
    if (job.conversion == CONV_O && job.alt && zr == 7'd0 &&
        (nd7 == 7'd0 || !job.mag_zero)) zr = 7'd1;
    body = (is_int ? {5'd0, job.npre} : 7'd0) + zr + nd7;
    pad  = ({1'b0, job.w} > body && job.conversion != CONV_PCT) ?
           {1'b0, job.w} - body : 7'd0;
    a     = (!job.left && !job.zfill) ? pad : 7'd0;
    b     = a + (is_int ? {5'd0, job.npre} : 7'd0);
    c     = b + (job.zfill ? pad : 7'd0) + zr;
    d     = c + nd7;
    total = d + (job.left ? pad : 7'd0);
  end

  always_comb begin
    in_dig = 1'b0;
    if (pos_r < a_r) ch = 8'h20;
    else if (pos_r < b_r) ch = (pos_r == a_r) ? pre0_r : pre1_r;
    else if (pos_r < c_r) ch = 8'h30;
    else if (pos_r < d_r) begin
      in_dig = 1'b1;
      case (conv_r)
        CONV_C:   ch = chr_r;
        CONV_PCT: ch = 8'h25;
        default:  ch = digit_char(dig_r[DIG_W-1 -: 4], conv_r == CONV_XU);
      endcase
    end else ch = 8'h20;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (!run_r && job_valid) begin
        // an empty field yields no output character at all
        run_r <= (total != 7'd0);
      end else if (fire && pos_r == total_r - 7'd1) begin
        run_r <= 1'b0;
      end
    end
    if (!run_r && job_valid) begin
      pos_r   <= 7'd0;
      a_r     <= a;
      b_r     <= b;
      c_r     <= c;
      d_r     <= d;
      total_r <= total;
      dig_r   <= job.dig;
      conv_r  <= job.conversion;
      pre0_r  <= job.pre0;
      pre1_r  <= job.pre1;
      chr_r   <= job.chr;
    end else if (fire) begin
      pos_r              <= pos_r + 7'd1;
      out_r.char_out     <= ch;
      out_r.last_char    <= (pos_r == total_r - 7'd1);
      if (in_dig) dig_r  <= {dig_r[DIG_W-5:0], 4'd0};
    end
  end

endmodule

@@ hw/rtl/printf_integer_field_formatter.sv @@
`timescale 1ns / 1ps
// conversion: d/u run bit-serial double dabble, then strip leading zeros, before the first
// character shows; x/X/o/p skip the double dabble pass and only strip; c and % skip both
// throughput: the converter takes the next request while the emitter sends one char a
// cycle whenever out_ready allows, so a request costs the larger of its converter time
// and its field length
// reset: synchronous active-low rst_n clears the control state and drops out_valid
module printf_integer_field_formatter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pif_pkg::pif_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pif_pkg::pif_out_t out_data
);
  import pif_pkg::*;

  pif_job_t job;
  logic     job_valid, job_ready;

  pif_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  pif_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/pif_field_checker.sv @@
`timescale 1ns / 1ps
module pif_field_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  pif_pkg::pif_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  pif_pkg::pif_out_t out_data,
  output int                fail_count,
  output int                pending_chars
);
  import pif_pkg::*;

  pif_out_t expected_chars[$];

  assign pending_chars = expected_chars.size();

  // builds the ascii field for one request and queues at most its first 64 characters
  task automatic format_field(input pif_in_t r);
    logic [7:0] field[$];
    logic [7:0] digs[$];
    logic [7:0] pre[$];
    logic [63:0] v, mag, mask, t;
    int bits, radix, w, prec, zeros, pad, body, dg;
    logic hp, left, zfill, upper;
    pif_out_t o;
    w = (r.field_width > MAX_WIDTH) ? MAX_WIDTH : int'(r.field_width);
    prec = (r.min_digits > MAX_PRECISION) ? MAX_PRECISION : int'(r.min_digits);
    hp = r.has_precision;
    left = r.left_justify;
    zeros = 0;
    if (r.conversion == CONV_PCT) begin
      field.push_back("%");
    end else if (r.conversion == CONV_C) begin
      pad = (w > 1) ? w - 1 : 0;
      if (!left) repeat (pad) field.push_back(" ");
      field.push_back(r.value[7:0]);
      if (left) repeat (pad) field.push_back(" ");
    end else begin
      if (r.conversion == CONV_P || r.length_mod == LEN_L || r.length_mod == LEN_LX) bits = 64;
      else if (r.length_mod == LEN_H) bits = 16;
      else bits = 32;
      mask = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
      v = r.value & mask;
      mag = v;
      if (r.conversion == CONV_D) begin
        if (v[bits-1]) begin
          mag = (64'd0 - v) & mask;
          pre.push_back("-");
        end else if (r.force_sign) pre.push_back("+");
        else if (r.space_sign) pre.push_back(" ");
      end
      radix = (r.conversion <= CONV_U) ? 10 : ((r.conversion == CONV_O) ? 8 : 16);
      upper = (r.conversion == CONV_XU);
      if (!(mag == 0 && hp && prec == 0)) begin
        t = mag;
        do begin
          dg = int'(t % radix);
          if (dg < 10) digs.push_front(8'h30 + 8'(dg));
          else digs.push_front((upper ? 8'h37 : 8'h57) + 8'(dg));
          t = t / radix;
        end while (t != 0);
      end
      if (hp && prec > digs.size()) zeros = prec - digs.size();
      if (r.conversion == CONV_O && r.alt_form && zeros == 0 &&
          (digs.size() == 0 || digs[0] != "0")) zeros = 1;
      if (((r.conversion == CONV_X || upper) && r.alt_form && mag != 0) ||
          (r.conversion == CONV_P && mag != 0)) begin
        pre.push_back("0");
        pre.push_back(upper ? "X" : "x");
      end
      body = pre.size() + zeros + digs.size();
      pad = (w > body) ? w - body : 0;
      zfill = r.zero_pad && !left && !hp;
      if (!left && !zfill) repeat (pad) field.push_back(" ");
      foreach (pre[i]) field.push_back(pre[i]);
      if (!left && zfill) repeat (pad) field.push_back("0");
      repeat (zeros) field.push_back("0");
      foreach (digs[i]) field.push_back(digs[i]);
      if (left) repeat (pad) field.push_back(" ");
    end
    foreach (field[i]) begin
      if (i < 64) begin
        o.char_out = field[i];
        o.last_char = (i + 1 == field.size() || i == 63);
        expected_chars.push_back(o);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count <= 0;
      expected_chars.delete();
    end else begin
      // results are checked before the new request is queued
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected char %h last %b", out_data.char_out, out_data.last_char);
          fail_count <= fail_count + 1;
        end else begin
          if (out_data !== expected_chars[0]) begin
            if (fail_count < 10)
              $display("char mismatch: expected %h/%b got %h/%b",
                       expected_chars[0].char_out, expected_chars[0].last_char,
                       out_data.char_out, out_data.last_char);
            fail_count <= fail_count + 1;
          end
          void'(expected_chars.pop_front());
        end
      end
      if (in_valid && in_ready) format_field(in_data);
    end
  end
endmodule

@@ tb/tb_printf_integer_field_formatter.sv @@
`timescale 1ns / 1ps
module tb_printf_integer_field_formatter;
  import pif_pkg::*;

  logic     clk = 0;
  logic     rst_n = 0;
  logic     in_valid = 0;
  logic     in_ready;
  pif_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 0;
  pif_out_t out_data;
  int       fail_count;
  int       pending_chars;
  logic     calm = 0;
  logic     hold_off = 0;

  always #1 clk = ~clk;

  printf_integer_field_formatter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  pif_field_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_chars(pending_chars)
  );

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return {$urandom, $urandom};
      2: return 64'd1 << $urandom_range(0, 63);
      3: return '1;
      4: return {32'd0, $urandom};
      5: return {48'd0, 16'h8000 | 16'($urandom)};
      6: return {32'hffffffff, 32'h80000000 | $urandom};
      default: return 64'($urandom_range(0, 99));
    endcase
  endfunction

  function automatic pif_in_t random_request();
    pif_in_t r;
    r = '0;
    r.conversion = 3'($urandom_range(0, 7));
    r.value = pick_value();
    r.length_mod = 2'($urandom_range(0, 3));
    {r.left_justify, r.force_sign, r.space_sign, r.alt_form, r.zero_pad, r.has_precision}
      = 6'($urandom);
    // mostly short fields, sometimes the extremes
    r.field_width = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 12));
    r.min_digits = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 8));
    return r;
  endfunction

  // valid stays up between requests unless an idle gap is inserted
  task automatic send(input pif_in_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic pif_in_t mk(input logic [2:0] cv, input logic [63:0] v,
                                 input logic [1:0] lm, input logic [5:0] fl,
                                 input logic [5:0] w, input logic hp, input logic [5:0] p);
    pif_in_t r;
    r.conversion = cv; r.value = v; r.length_mod = lm;
    {r.left_justify, r.force_sign, r.space_sign, r.alt_form, r.zero_pad} = fl[4:0];
    r.field_width = w; r.has_precision = hp; r.min_digits = p;
    return r;
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    logic hold_done;
    hold_done = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off && !hold_done) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_done = 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ready <= 1;
      end else out_ready <= 1;
    end
  end

  initial begin
    pif_in_t r;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: every conversion, extremes, flags and special cases
    send(mk(CONV_D, 64'h80000000, LEN_INT, 6'b01000, 6'd0, 0, 6'd0));
    send(mk(CONV_D, 64'h8000000000000000, LEN_L, 6'b00000, 6'd25, 0, 6'd0));
    send(mk(CONV_D, 64'h7fff, LEN_H, 6'b01000, 6'd8, 0, 6'd0));
    send(mk(CONV_D, 64'd42, LEN_INT, 6'b00100, 6'd0, 0, 6'd0));
    send(mk(CONV_D, 64'd42, LEN_INT, 6'b01100, 6'd0, 0, 6'd0));
    send(mk(CONV_D, 64'hffff, LEN_H, 6'b00001, 6'd10, 0, 6'd0));
    send(mk(CONV_D, 64'hfffffffe, LEN_INT, 6'b10001, 6'd10, 0, 6'd0));
    send(mk(CONV_U, 64'hffffffffffffffff, LEN_LX, 6'b00000, 6'd63, 0, 6'd0));
    send(mk(CONV_U, 64'd0, LEN_INT, 6'b00000, 6'd0, 1, 6'd0));
    send(mk(CONV_U, 64'd0, LEN_INT, 6'b00000, 6'd5, 1, 6'd0));
    send(mk(CONV_U, 64'd7, LEN_INT, 6'b00001, 6'd63, 1, 6'd63));
    send(mk(CONV_X, 64'hdeadbeef, LEN_INT, 6'b00011, 6'd12, 0, 6'd0));
    send(mk(CONV_X, 64'd0, LEN_INT, 6'b00010, 6'd4, 0, 6'd0));
    send(mk(CONV_XU, 64'hcafef00d12345678, LEN_L, 6'b10010, 6'd24, 1, 6'd18));
    send(mk(CONV_O, 64'd8, LEN_INT, 6'b00010, 6'd0, 0, 6'd0));
    send(mk(CONV_O, 64'd0, LEN_INT, 6'b00010, 6'd0, 1, 6'd0));
    send(mk(CONV_O, 64'hffffffffffffffff, LEN_L, 6'b00010, 6'd0, 1, 6'd3));
    send(mk(CONV_P, 64'd0, LEN_INT, 6'b00000, 6'd6, 0, 6'd0));
    send(mk(CONV_P, 64'h0000ffff12345678, LEN_H, 6'b00001, 6'd20, 0, 6'd0));
    send(mk(CONV_C, 64'h41, LEN_INT, 6'b11111, 6'd5, 1, 6'd9));
    send(mk(CONV_C, 64'h100, LEN_INT, 6'b10000, 6'd63, 0, 6'd0));
    send(mk(CONV_PCT, '1, LEN_LX, 6'b11111, 6'd63, 1, 6'd63));
    // sender pauses until the block drains
    in_valid <= 0;
    @(posedge clk);
    wait (pending_chars == 0);
    repeat (100) @(posedge clk);
    for (int n = 0; n < 400; n++) begin
      if (n == 150) hold_off <= 1;
      if (n == 330) calm <= 1;
      r = random_request();
      send(r);
    end
    in_valid <= 0;
    @(posedge clk);
    wait (pending_chars == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
